// ===== design/crng_pkg.sv =====
// Shared constants and types of the combined LCG shuffle random number generator.
`timescale 1ns / 1ps

package crng_pkg;

  localparam logic [31:0] MOD_A       = 32'd2147483563;
  localparam logic [31:0] MOD_B       = 32'd2147483399;
  localparam logic [15:0] MUL_A       = 16'd40014;
  localparam logic [15:0] MUL_B       = 16'd40692;
  // 2^31 mod MOD_A and 2^31 mod MOD_B
  localparam logic [6:0]  FOLD_A      = 7'd85;
  localparam logic [7:0]  FOLD_B      = 8'd249;
  localparam logic [31:0] SAMPLE_WRAP = 32'd2147483562;
  localparam logic [30:0] SECOND_INIT = 31'd123456789;
  localparam logic [30:0] SEED_INIT   = 31'd1;
  localparam logic [23:0] FRAC_MAX    = 24'd16777214;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_WARM_MUL,
    ST_WARM_RED,
    ST_MUL_A,
    ST_RED_A,
    ST_RED_B,
    ST_SWAP,
    ST_SAMPLE,
    ST_FINISH
  } crng_state_t;

  typedef struct packed {
    logic seed_load;
    logic mul_first;
    logic mul_second;
    logic red_first;
    logic red_second;
    logic warm_step;
    logic slot_est;
    logic slot_mul;
    logic slot_fix;
    logic tbl_swap;
    logic sample_ld;
    logic out_ld;
  } crng_cmd_t;

  typedef struct packed {
    logic first_zero;
    logic cnt_zero;
    logic out_free;
  } crng_status_t;

endpackage

// ===== design/combined_lcg_shuffle_rng.sv =====
// Top level of the combined two-LCG random number generator with shuffle table.
// A new draw is taken only once the last one has been loaded into the output register.
// A reseed (or the first draw after reset) also loads the seed and runs the warm-up that fills the table.
// One multiply-reduce unit steps both generators in turn,
// then the table slot is read and rewritten through its single port.
// Synchronous active-low reset leaves the block unseeded with seed 1; no clearing pass.
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_reseed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_sample,
  output logic [23:0] out_fraction,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata
);

  crng_pkg::crng_cmd_t    cmd;
  crng_pkg::crng_status_t status;

  crng_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_reseed (in_reseed),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  crng_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_sample   (out_sample),
    .out_fraction (out_fraction)
  );

endmodule

// ===== design/crng_ctrl.sv =====
// Sequencing state machine for seeding, warm-up and draws.
`timescale 1ns / 1ps

module crng_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_reseed,
  output logic                  in_stall,
  input  crng_pkg::crng_status_t status,
  output crng_pkg::crng_cmd_t    cmd
);

  crng_pkg::crng_state_t state_r;
  crng_pkg::crng_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crng_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      crng_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_reseed || status.first_zero) begin
            state_nxt = crng_pkg::ST_SEED;
          end else begin
            state_nxt = crng_pkg::ST_MUL_A;
          end
        end
      end
      crng_pkg::ST_SEED: begin
        cmd.seed_load = 1'b1;
        state_nxt     = crng_pkg::ST_WARM_MUL;
      end
      crng_pkg::ST_WARM_MUL: begin
        cmd.mul_first = 1'b1;
        state_nxt     = crng_pkg::ST_WARM_RED;
      end
      crng_pkg::ST_WARM_RED: begin
        cmd.red_first = 1'b1;
        cmd.warm_step = 1'b1;
        if (status.cnt_zero) begin
          state_nxt = crng_pkg::ST_MUL_A;
        end else begin
          state_nxt = crng_pkg::ST_WARM_MUL;
        end
      end
      crng_pkg::ST_MUL_A: begin
        cmd.mul_first = 1'b1;
        cmd.slot_est  = 1'b1;
        state_nxt     = crng_pkg::ST_RED_A;
      end
      crng_pkg::ST_RED_A: begin
        cmd.red_first  = 1'b1;
        cmd.mul_second = 1'b1;
        cmd.slot_mul   = 1'b1;
        state_nxt      = crng_pkg::ST_RED_B;
      end
      crng_pkg::ST_RED_B: begin
        cmd.red_second = 1'b1;
        cmd.slot_fix   = 1'b1;
        state_nxt      = crng_pkg::ST_SWAP;
      end
      crng_pkg::ST_SWAP: begin
        cmd.tbl_swap = 1'b1;
        state_nxt    = crng_pkg::ST_SAMPLE;
      end
      crng_pkg::ST_SAMPLE: begin
        cmd.sample_ld = 1'b1;
        state_nxt     = crng_pkg::ST_FINISH;
      end
      crng_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = crng_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = crng_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/crng_dp.sv =====
// Datapath: generator state, shared multiply-reduce unit, shuffle table, slot and fraction logic.
`timescale 1ns / 1ps

module crng_dp #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  crng_pkg::crng_cmd_t    cmd,
  output crng_pkg::crng_status_t status,
  input  logic                   cfg_we,
  input  logic [30:0]            cfg_wdata,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [30:0]            out_sample,
  output logic [23:0]            out_fraction
);

  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 8);
  localparam int WARM_LAST = TABLE_DEPTH + 7;
  localparam logic [63:0] SLOT_DIV =
    64'(crng_pkg::SAMPLE_WRAP) / 64'(TABLE_DEPTH) + 64'd1;
  localparam logic [63:0] RECIP = (64'd1 << 31) / SLOT_DIV;
  localparam int QW = $clog2(RECIP + 64'd2);
  localparam int PW = 31 + QW;

  function automatic logic [30:0] fold_a(input logic [46:0] p);
    logic [31:0] t;
    t = {1'b0, p[30:0]} + 32'(p[46:31]) * 32'(crng_pkg::FOLD_A);
    if (t >= crng_pkg::MOD_A) t = t - crng_pkg::MOD_A;
    return t[30:0];
  endfunction

  function automatic logic [30:0] fold_b(input logic [46:0] p);
    logic [31:0] t;
    t = {1'b0, p[30:0]} + 32'(p[46:31]) * 32'(crng_pkg::FOLD_B);
    if (t >= crng_pkg::MOD_B) t = t - crng_pkg::MOD_B;
    return t[30:0];
  endfunction

  logic [30:0]       seed_r;
  logic [30:0]       first_r;
  logic [30:0]       second_r;
  logic [30:0]       shuf_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [46:0]       prod_r;
  logic [QW-1:0]     qest_r;
  logic [PW-1:0]     qd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [30:0]       tbl_rd_r;
  logic              out_valid_r;
  logic [30:0]       out_sample_r;
  logic [23:0]       out_frac_r;
  logic [30:0]       tbl_mem [TABLE_DEPTH];

  logic [30:0]       mul_op;
  logic [15:0]       mul_k;
  logic [46:0]       prod_nxt;
  logic [30:0]       red_a;
  logic [30:0]       red_b;
  logic [31:0]       seed_ext;
  logic [31:0]       seed_mod;
  logic [30:0]       seed_nxt;
  logic [PW-1:0]     rcp_prod;
  logic [QW-1:0]     qest_nxt;
  logic [PW-1:0]     qd_nxt;
  logic [PW-1:0]     rem;
  logic [QW:0]       qsum;
  logic [SLOT_W-1:0] slot_nxt;
  logic [31:0]       diff;
  logic [31:0]       samp;
  logic [30:0]       shuf_nxt;
  logic [23:0]       f0;
  logic [24:0]       f1;
  logic [32:0]       chk;
  logic [24:0]       frac25;
  logic [23:0]       frac_nxt;
  logic              tbl_we;
  logic [SLOT_W-1:0] tbl_wa;
  logic [30:0]       tbl_wd;

  // shared multiplier, operand picked by command
  assign mul_op   = cmd.mul_second ? second_r : first_r;
  assign mul_k    = cmd.mul_second ? crng_pkg::MUL_B : crng_pkg::MUL_A;
  assign prod_nxt = 47'(mul_op) * 47'(mul_k);
  assign red_a    = fold_a(prod_r);
  assign red_b    = fold_b(prod_r);

  assign seed_ext = {1'b0, seed_r};
  assign seed_mod = (seed_ext >= crng_pkg::MOD_A) ? seed_ext - crng_pkg::MOD_A : seed_ext;
  assign seed_nxt = (seed_mod == 32'd0) ? crng_pkg::SEED_INIT : seed_mod[30:0];

  // slot = shuf / SLOT_DIV: reciprocal estimate, then one correction
  assign rcp_prod = PW'(shuf_r) * PW'(RECIP);
  assign qest_nxt = rcp_prod[PW-1:31];
  assign qd_nxt   = PW'(qest_r) * PW'(SLOT_DIV);
  assign rem      = PW'(shuf_r) - qd_r;
  assign qsum     = {1'b0, qest_r} + (QW+1)'(rem >= PW'(SLOT_DIV));
  assign slot_nxt = (qsum >= (QW+1)'(TABLE_DEPTH)) ? SLOT_W'(TABLE_DEPTH - 1)
                                                    : qsum[SLOT_W-1:0];

  assign diff     = {1'b0, tbl_rd_r} - {1'b0, second_r};
  assign samp     = (diff[31] || diff == 32'd0) ? diff + crng_pkg::SAMPLE_WRAP : diff;
  assign shuf_nxt = samp[30:0];

  // floor(x*2^24/MOD_A) is x>>7 or one more
  assign f0       = shuf_r[30:7];
  assign f1       = {1'b0, f0} + 25'd1;
  assign chk      = 33'({shuf_r[6:0], 24'd0}) + 33'(f1) * 33'(crng_pkg::FOLD_A);
  assign frac25   = (chk >= 33'h0_8000_0000) ? f1 : {1'b0, f0};
  assign frac_nxt = (frac25 > 25'(crng_pkg::FRAC_MAX)) ? crng_pkg::FRAC_MAX : frac25[23:0];

  assign tbl_we = (cmd.warm_step && (cnt_r < CNT_W'(TABLE_DEPTH))) || cmd.tbl_swap;
  assign tbl_wa = cmd.tbl_swap ? slot_r : cnt_r[SLOT_W-1:0];
  assign tbl_wd = cmd.tbl_swap ? first_r : red_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= crng_pkg::SEED_INIT;
      first_r     <= '0;
      second_r    <= crng_pkg::SECOND_INIT;
      shuf_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) seed_r <= cfg_wdata;
      if (cmd.seed_load) begin
        first_r  <= seed_nxt;
        second_r <= seed_nxt;
        cnt_r    <= CNT_W'(WARM_LAST);
      end
      if (cmd.red_first) first_r <= red_a;
      if (cmd.red_second) second_r <= red_b;
      if (cmd.warm_step) begin
        if (cnt_r == '0) begin
          shuf_r <= red_a;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
      if (cmd.sample_ld) shuf_r <= shuf_nxt;
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_first || cmd.mul_second) prod_r <= prod_nxt;
    if (cmd.slot_est) qest_r <= qest_nxt;
    if (cmd.slot_mul) qd_r <= qd_nxt;
    if (cmd.slot_fix) slot_r <= slot_nxt;
    if (cmd.out_ld) begin
      out_sample_r <= shuf_r;
      out_frac_r   <= frac_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    if (cmd.tbl_swap) tbl_rd_r <= tbl_mem[slot_r];
  end

  assign status.first_zero = (first_r == '0);
  assign status.cnt_zero   = (cnt_r == '0);
  assign status.out_free   = !out_valid_r || !out_stall;

  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_fraction = out_frac_r;

endmodule

// ===== design/crng_checker.sv =====
// Port-level assertion checker for the generator, bound to the top level.
`timescale 1ns / 1ps

module crng_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [30:0] out_sample,
  input logic [23:0] out_fraction
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_sample) && $stable(out_fraction))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a draw is in progress");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample != 31'd0) && (out_sample <= 31'd2147483562))
    else $error("sample out of range");

  a_frac_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fraction == out_sample[30:7])
               || (out_fraction == out_sample[30:7] + 24'd1)
               || (out_fraction == 24'd16777214))
    else $error("fraction does not match sample");

endmodule

bind combined_lcg_shuffle_rng crng_checker u_crng_checker (.*);

// ===== tb/sv/combined_lcg_shuffle_rng_tb.sv =====
// Self-checking testbench for the combined LCG shuffle random number generator.
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng_tb;

  localparam int DEPTH = 32;
  localparam int WARM_STEPS = DEPTH + 8;
  localparam longint unsigned SLOT_DIV = 1 + crng_pkg::SAMPLE_WRAP / DEPTH;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_DRAWS = 225;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [30:0] sample;
    logic [23:0] fraction;
  } draw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_reseed = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [30:0] out_sample;
  logic [23:0] out_fraction;
  logic        cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;

  // generator model state
  logic [30:0] seed_reg;
  logic [30:0] gen_first;
  logic [30:0] gen_second;
  logic [30:0] last_sample;
  logic [30:0] shuffle_tbl [DEPTH];

  bit     reseed_queue[$];
  draw_t  expected_draws[$];
  bit     idle_en = 1'b1;
  int     send_gap = 0;
  int     stall_left = 0;
  int     hold_left = 0;
  int     hold_requests = 0;
  int     hold_served = 0;
  int     mismatch_count = 0;
  int     draws_checked = 0;
  int     reseeds_sent = 0;
  int     saturated_seen = 0;
  int     seeds_used = 0;

  combined_lcg_shuffle_rng #(.TABLE_DEPTH(DEPTH)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_reseed   (in_reseed),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (out_sample),
    .out_fraction(out_fraction),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [30:0] lcg_advance(logic [30:0] x, logic [63:0] mul,
                                              logic [63:0] modulus);
    logic [63:0] prod;
    prod = mul * {33'd0, x};
    return 31'(prod % modulus);
  endfunction

  task automatic reset_model();
    seed_reg = crng_pkg::SEED_INIT;
    gen_first = '0;
    gen_second = crng_pkg::SECOND_INIT;
    last_sample = '0;
    foreach (shuffle_tbl[i]) shuffle_tbl[i] = '0;
  endtask

  task automatic seed_generators();
    logic [31:0] s;
    s = {1'b0, seed_reg};
    if (s >= crng_pkg::MOD_A) s = s - crng_pkg::MOD_A;
    if (s == 0) s = 1;
    gen_first = s[30:0];
    gen_second = s[30:0];
    for (int j = WARM_STEPS - 1; j >= 0; j--) begin
      gen_first = lcg_advance(gen_first, 64'(crng_pkg::MUL_A), 64'(crng_pkg::MOD_A));
      if (j < DEPTH) shuffle_tbl[j] = gen_first;
    end
    last_sample = shuffle_tbl[0];
  endtask

  task automatic predict_draw(input bit reseed);
    longint      slot;
    longint      diff;
    logic [63:0] frac;
    draw_t       d;
    if (reseed || gen_first == 0) seed_generators();
    gen_first = lcg_advance(gen_first, 64'(crng_pkg::MUL_A), 64'(crng_pkg::MOD_A));
    gen_second = lcg_advance(gen_second, 64'(crng_pkg::MUL_B), 64'(crng_pkg::MOD_B));
    slot = longint'(last_sample) / longint'(SLOT_DIV);
    if (slot >= DEPTH) slot = DEPTH - 1;
    diff = longint'(shuffle_tbl[slot]) - longint'(gen_second);
    shuffle_tbl[slot] = gen_first;
    if (diff < 1) diff = diff + longint'(crng_pkg::SAMPLE_WRAP);
    last_sample = 31'(diff);
    frac = ({33'd0, last_sample} << 24) / 64'(crng_pkg::MOD_A);
    if (frac > 64'(crng_pkg::FRAC_MAX)) frac = 64'(crng_pkg::FRAC_MAX);
    d.sample = last_sample;
    d.fraction = frac[23:0];
    expected_draws.push_back(d);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // input driver
  always @(posedge clk) begin
    logic nv, nr;
    nv = in_valid;
    nr = in_reseed;
    if (in_valid && !in_stall) begin
      predict_draw(in_reseed);
      if (in_reseed) reseeds_sent++;
      nv = 1'b0;
    end
    if (!nv && rst_n) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (reseed_queue.size() > 0) begin
        if (idle_en && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 19) - 1;
        end else begin
          nv = 1'b1;
          nr = reseed_queue.pop_front();
        end
      end
    end
    in_valid <= nv;
    in_reseed <= nr;
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    logic  ns;
    draw_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_draws.size() == 0) begin
        report_mismatch("unexpected transfer, sample", out_sample, -1);
      end else begin
        want = expected_draws.pop_front();
        draws_checked++;
        if (out_sample !== want.sample) report_mismatch("sample", out_sample, want.sample);
        if (out_fraction !== want.fraction)
          report_mismatch("fraction", out_fraction, want.fraction);
        if (want.fraction == crng_pkg::FRAC_MAX) saturated_seen++;
      end
    end
    ns = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      ns = 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      ns = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      ns = 1'b1;
    end else if (idle_en && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      ns = 1'b1;
    end
    out_stall <= ns;
  end

  task automatic wait_for_results();
    @(negedge clk);
    while (reseed_queue.size() > 0 || in_valid || expected_draws.size() > 0 ||
           hold_left > 0)
      @(negedge clk);
  endtask

  task automatic write_seed(input logic [30:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    seed_reg = value;
    seeds_used++;
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_draws(input int count);
    repeat (count) reseed_queue.push_back($urandom_range(0, 15) == 0);
  endtask

  task automatic seeded_burst(input logic [30:0] value);
    write_seed(value);
    reseed_queue.push_back(1'b1);
    reseed_queue.push_back(1'b0);
    reseed_queue.push_back(1'b0);
    wait_for_results();
  endtask

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // unseeded first draw, then an explicit reseed from the reset seed
    reseed_queue.push_back(1'b0);
    reseed_queue.push_back(1'b0);
    reseed_queue.push_back(1'b1);
    reseed_queue.push_back(1'b0);
    wait_for_results();

    seeded_burst(31'd0);            // zero seed acts as one
    seeded_burst(31'd2147483563);   // modulus wraps to zero, then one
    seeded_burst(31'h7fffffff);     // largest register value, above modulus
    seeded_burst(31'd2147483399);   // second generator collapses to zero
    seeded_burst(31'd2147483562);   // largest seed below modulus

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 3)
        write_seed(31'($urandom_range(32'h7fffffff, crng_pkg::MOD_A)));
      else
        write_seed(31'($urandom()));
      if (p == RANDOM_PHASES - 1) idle_en = 1'b0;
      queue_draws(PHASE_DRAWS);
      if (p == 1) hold_requests++;
      wait_for_results();
    end

    repeat (20) @(posedge clk);
    if (expected_draws.size() != 0)
      report_mismatch("draws never delivered", 0, expected_draws.size());
    $display("Checked %0d draws, %0d with reseed, across %0d seed writes.",
             draws_checked, reseeds_sent, seeds_used);
    $display("Fraction clamp hit %0d times; long output hold and drain pauses exercised.",
             saturated_seen);
    if (mismatch_count == 0) begin
      $display("combined_lcg_shuffle_rng test passed");
    end else begin
      $display("combined_lcg_shuffle_rng test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout at %0t", $time);
    $display("combined_lcg_shuffle_rng test failed");
    $finish;
  end

endmodule
